// ----- rtl/lrq_pkg.sv -----
package lrq_pkg;

    // Fixed field widths of the stream words
    localparam int ID_W        = 16;
    localparam int RT_FIELD_W  = 48;
    localparam int OCC_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_RUNTIME_BITS = 48;

    // Operation carried in the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    latch;       // capture the input word
        logic    insert;      // append the latched task, count up, result ok
        logic    res_load;    // set a result with zero task fields
        t_status res_code;    // status for res_load
        logic    scan_start;  // read slot 0
        logic    scan_step;   // compare the slot just read, read the next one
        logic    move_start;  // read the slot behind the chosen one
        logic    move_step;   // write the slot just read one place lower
        logic    pop_done;    // count down, result ok with the chosen task
        logic    load_out;    // move the result to the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_pop;     // latched operation is a pop
        logic empty;      // no task queued
        logic full;       // every slot taken
        logic at_last;    // the slot just read is the last queued one
        logic best_last;  // the chosen slot is the last queued one
        logic out_free;   // output register can take a result this cycle
    } t_dp_sts;

endpackage

// ----- rtl/least_runtime_run_queue.sv -----
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   task_id[15:0] runtime[63:16]                op (0 insert, 1 pop)
// m_axis    out  chosen_id[15:0] chosen_runtime[63:16]       status (0 ok, 1 empty,
//                occupancy[68:64] zero[71:69]                2 full)
//
// One word in, one word out, one word at a time. Insert, a pop on an empty
// queue and an insert into a full queue go from accept through S_EXEC to
// S_DONE. A pop goes through S_EXEC, S_SCAN, S_MOVE (skipped when the chosen
// task is the last queued one) and S_DONE: the slot memory has one read port
// and is read once per slot to find the minimum, then once per slot behind it to close the gap.
// Reset (synchronous, active low) empties the queue; slot contents are not
// cleared. A result waiting on m_axis does not block the next accept; only
// the load of the following result waits for m_tready.
module least_runtime_run_queue
    import lrq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int RUNTIME_BITS = DEF_RUNTIME_BITS
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side: insert or pop request
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // task_id[15:0], runtime[63:16]
    input  logic                   i_s_tuser,   // op[0]
    // master side: one result word per request
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // chosen_id[15:0], chosen_runtime[63:16],
                                                // occupancy[68:64], zero[71:69]
    output t_status                o_m_tuser    // status[1:0]
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: accept, insert or scan/compact, hand off result
    lrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // slot memory, minimum tracker, count and output register
    lrq_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .RUNTIME_BITS (RUNTIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

// ----- rtl/lrq_ctrl.sv -----
module lrq_ctrl
    import lrq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.op_pop) begin
                    if (i_sts.full) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = ST_FULL;
                    end else begin
                        o_cmd.insert = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (i_sts.empty) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_EMPTY;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.at_last) begin
                    if (i_sts.best_last) begin
                        o_cmd.pop_done = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.move_start = 1'b1;
                        n_state          = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                o_cmd.move_step = 1'b1;
                if (i_sts.at_last) begin
                    o_cmd.pop_done = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lrq_dp.sv -----
module lrq_dp
    import lrq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int RUNTIME_BITS = DEF_RUNTIME_BITS
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output t_status                o_m_tuser,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts
);

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int WW     = ID_W + RUNTIME_BITS;
    localparam int OUT_PAD = OUT_TDATA_W - OCC_W - RT_FIELD_W - ID_W;
    localparam logic [63:0] RT_MAX =
        (RUNTIME_BITS >= 64) ? {64{1'b1}} : ((64'd1 << RUNTIME_BITS) - 64'd1);

    // slot store: {runtime, id} in insertion order
    logic [WW-1:0] mem [QUEUE_DEPTH];

    logic                    r_op;
    logic [ID_W-1:0]         r_id;
    logic [RUNTIME_BITS-1:0] r_rt;
    logic [CW-1:0]           r_count;
    logic [WW-1:0]           r_rd_data;
    logic [AW-1:0]           r_rd_addr;
    logic [AW-1:0]           r_best_idx;
    logic [ID_W-1:0]         r_best_id;
    logic [RUNTIME_BITS-1:0] r_best_rt;
    t_status                 r_res_status;
    logic [ID_W-1:0]         r_res_id;
    logic [RUNTIME_BITS-1:0] r_res_rt;
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [ID_W-1:0]         r_out_id;
    logic [RT_FIELD_W-1:0]   r_out_rt;
    logic [OCC_W-1:0]        r_out_occ;

    logic [63:0]             in_rt64;
    logic [RUNTIME_BITS-1:0] in_rt_sat;
    logic [ID_W-1:0]         rd_id;
    logic [RUNTIME_BITS-1:0] rd_rt;
    logic                    take;
    logic [AW-1:0]           n_best_idx;
    logic [ID_W-1:0]         n_best_id;
    logic [RUNTIME_BITS-1:0] n_best_rt;
    logic [AW-1:0]           last_addr;
    logic                    at_last;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [WW-1:0]           wr_data;
    logic                    out_free;

    // clamp the incoming runtime to the stored width
    assign in_rt64   = 64'(i_s_tdata[ID_W +: RT_FIELD_W]);
    assign in_rt_sat = RUNTIME_BITS'((in_rt64 > RT_MAX) ? RT_MAX : in_rt64);

    assign rd_id     = r_rd_data[ID_W-1:0];
    assign rd_rt     = r_rd_data[ID_W +: RUNTIME_BITS];
    assign last_addr = AW'(r_count - CW'(1));
    assign at_last   = (r_rd_addr == last_addr);

    // running minimum; strict compare keeps the earliest on ties
    always_comb begin
        take       = i_cmd.scan_step && ((r_rd_addr == '0) || (rd_rt < r_best_rt));
        n_best_idx = take ? r_rd_addr : r_best_idx;
        n_best_id  = take ? rd_id : r_best_id;
        n_best_rt  = take ? rd_rt : r_best_rt;
    end

    always_comb begin
        rd_en = i_cmd.scan_start | i_cmd.move_start
              | ((i_cmd.scan_step | i_cmd.move_step) & ~at_last);
        if (i_cmd.scan_start) begin
            rd_addr = '0;
        end else if (i_cmd.move_start) begin
            rd_addr = AW'(n_best_idx + AW'(1));
        end else begin
            rd_addr = AW'(r_rd_addr + AW'(1));
        end
        wr_en   = i_cmd.insert | i_cmd.move_step;
        wr_addr = i_cmd.insert ? AW'(r_count) : AW'(r_rd_addr - AW'(1));
        wr_data = i_cmd.insert ? {r_rt, r_id} : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_s_tuser;
            r_id <= i_s_tdata[ID_W-1:0];
            r_rt <= in_rt_sat;
        end
        if (i_cmd.scan_step) begin
            r_best_idx <= n_best_idx;
            r_best_id  <= n_best_id;
            r_best_rt  <= n_best_rt;
        end
        if (i_cmd.insert || i_cmd.res_load) begin
            r_res_status <= i_cmd.insert ? ST_OK : i_cmd.res_code;
            r_res_id     <= '0;
            r_res_rt     <= '0;
        end else if (i_cmd.pop_done) begin
            r_res_status <= ST_OK;
            r_res_id     <= n_best_id;
            r_res_rt     <= n_best_rt;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_rt     <= RT_FIELD_W'(r_res_rt);
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_count <= CW'(r_count + CW'(1));
            end else if (i_cmd.pop_done) begin
                r_count <= CW'(r_count - CW'(1));
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free = ~r_out_valid | i_m_tready;

    always_comb begin
        o_sts.op_pop    = (r_op == OP_POP);
        o_sts.empty     = (r_count == '0);
        o_sts.full      = (r_count == CW'(QUEUE_DEPTH));
        o_sts.at_last   = at_last;
        o_sts.best_last = (n_best_idx == last_addr);
        o_sts.out_free  = out_free;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{OUT_PAD{1'b0}}, r_out_occ, r_out_rt, r_out_id};

endmodule

// ----- rtl/lrq_checker.sv -----
module lrq_checker
    import lrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input t_status                o_m_tuser
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

    // one word in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted twice in a row");

    // only ok pops carry a task
    a_zero_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tdata[63:0] == 64'd0))
        else $error("task fields set on a non-ok result");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_EMPTY) |-> (o_m_tdata[68:64] == 5'd0))
        else $error("empty result with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_FULL) |-> (o_m_tdata[68:64] == FULL_OCC))
        else $error("full result with wrong occupancy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output word changed");

endmodule

bind least_runtime_run_queue lrq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lrq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- sim/least_runtime_run_queue_tb.sv -----
module least_runtime_run_queue_tb;
    import lrq_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int RAND_WORDS  = 400;
    localparam int IDLE_LIMIT  = 1000;   // cycles with no word moving on either side
    localparam int DRAIN_WAIT  = 64;     // longer than a full-queue pop
    localparam int HOLD_AFTER  = 150;    // results seen before the long output stall
    localparam int HOLD_CYCLES = 300;

    localparam logic [RT_FIELD_W-1:0] RT_ONES = '1;
    localparam logic [RT_FIELD_W-1:0] RT_CAP  = (DEF_RUNTIME_BITS >= RT_FIELD_W) ? RT_ONES :
        RT_FIELD_W'((64'd1 << DEF_RUNTIME_BITS) - 64'd1);

    typedef struct packed {
        t_status               status;
        logic [ID_W-1:0]       id;
        logic [RT_FIELD_W-1:0] rt;
        logic [OCC_W-1:0]      occ;
    } t_run_result;

    // Directed rows: rnd draws id/runtime at random, reps repeats the row,
    // chk means the expected word below is used instead of the predictor's.
    typedef struct packed {
        logic                  op;
        logic                  rnd;
        logic [4:0]            reps;
        logic [ID_W-1:0]       id;
        logic [RT_FIELD_W-1:0] rt;
        logic                  chk;
        t_run_result           want;
    } t_dir_row;

    localparam int DIR_ROWS = 15;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // pop right after reset: empty
        '{OP_POP,    1'b0, 5'd1,  16'h0000, 48'h0,     1'b1, '{ST_EMPTY, 16'h0, 48'h0, 5'd0}},
        // zero id / zero runtime, then all-ones id / all-ones runtime
        '{OP_INSERT, 1'b0, 5'd1,  16'h0000, 48'h0,     1'b1, '{ST_OK, 16'h0, 48'h0, 5'd1}},
        '{OP_INSERT, 1'b0, 5'd1,  16'hffff, RT_ONES,   1'b1, '{ST_OK, 16'h0, 48'h0, 5'd2}},
        '{OP_POP,    1'b0, 5'd1,  16'h0000, 48'h0,     1'b1, '{ST_OK, 16'h0, 48'h0, 5'd1}},
        // all-ones runtime is still picked when it is the only one left
        '{OP_POP,    1'b0, 5'd1,  16'h0000, 48'h0,     1'b1, '{ST_OK, 16'hffff, RT_ONES, 5'd0}},
        '{OP_POP,    1'b0, 5'd1,  16'h0000, 48'h0,     1'b1, '{ST_EMPTY, 16'h0, 48'h0, 5'd0}},
        // ties on all-ones: earliest wins
        '{OP_INSERT, 1'b0, 5'd1,  16'h0001, RT_ONES,   1'b1, '{ST_OK, 16'h0, 48'h0, 5'd1}},
        '{OP_INSERT, 1'b0, 5'd1,  16'h0002, RT_ONES,   1'b1, '{ST_OK, 16'h0, 48'h0, 5'd2}},
        '{OP_INSERT, 1'b0, 5'd1,  16'h0003, RT_ONES,   1'b1, '{ST_OK, 16'h0, 48'h0, 5'd3}},
        '{OP_POP,    1'b0, 5'd1,  16'h0000, 48'h0,     1'b1, '{ST_OK, 16'h0001, RT_ONES, 5'd2}},
        // fill up to the brim
        '{OP_INSERT, 1'b0, 5'd1,  16'h5a5a, 48'h100,   1'b0, '0},
        '{OP_INSERT, 1'b1, 5'd13, 16'h0000, 48'h0,     1'b0, '0},
        // insert into a full queue is dropped
        '{OP_INSERT, 1'b0, 5'd1,  16'h1234, 48'h5,     1'b1, '{ST_FULL, 16'h0, 48'h0, 5'd16}},
        // drain it, one pop past empty
        '{OP_POP,    1'b0, 5'd1,  16'h0000, 48'h0,     1'b0, '0},
        '{OP_POP,    1'b0, 5'd16, 16'h0000, 48'h0,     1'b0, '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;   // task_id[15:0], runtime[63:16]
    logic                   i_s_tuser = OP_INSERT;   // op[0]
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;        // chosen_id[15:0], chosen_runtime[63:16],
                                              // occupancy[68:64], zero[71:69]
    t_status                o_m_tuser;        // status[1:0]

    // model of the queue contents, in insertion order
    logic [ID_W-1:0]       rq_id [DEPTH];
    logic [RT_FIELD_W-1:0] rq_rt [DEPTH];
    int                    rq_count = 0;

    t_run_result pending_results[$];
    int          err_count = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    bit          send_burst = 1'b0;       // sender skips its gaps

    least_runtime_run_queue uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Least-runtime queue step: returns the result word one request produces.
    function automatic t_run_result apply_to_queue(logic op, logic [ID_W-1:0] id,
                                                   logic [RT_FIELD_W-1:0] rt);
        t_run_result r;
        int best;
        r = '0;
        if (op == OP_INSERT) begin
            if (rq_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                rq_id[rq_count] = id;
                rq_rt[rq_count] = (rt > RT_CAP) ? RT_CAP : rt;
                rq_count++;
                r.status = ST_OK;
            end
        end else if (rq_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            // strict less-than: ties keep the older entry
            best = 0;
            for (int i = 1; i < rq_count; i++) begin
                if (rq_rt[i] < rq_rt[best])
                    best = i;
            end
            r.status = ST_OK;
            r.id     = rq_id[best];
            r.rt     = rq_rt[best];
            for (int i = best; i + 1 < rq_count; i++) begin
                rq_id[i] = rq_id[i + 1];
                rq_rt[i] = rq_rt[i + 1];
            end
            rq_count--;
        end
        r.occ = OCC_W'(rq_count);
        return r;
    endfunction

    // Drive one request word at the falling edge; wait for the accept edge.
    task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                                input logic [RT_FIELD_W-1:0] rt, input bit use_typed,
                                input t_run_result typed);
        int gap;
        t_run_result predicted;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {rt, id};
        i_s_tuser  = op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = apply_to_queue(op, id, rt);
        pending_results.push_back(use_typed ? typed : predicted);
        @(negedge i_clk);
    endtask

    // Runtime mix: lots of small values so ties show up, plus both extremes.
    function automatic logic [RT_FIELD_W-1:0] pick_runtime();
        logic [63:0] wide;
        int sel;
        sel  = $urandom_range(0, 9);
        wide = {$urandom, $urandom};
        case (sel)
            0:       return '0;
            1:       return RT_ONES;
            2, 3, 4: return RT_FIELD_W'($urandom_range(0, 7));
            5:       return RT_ONES - RT_FIELD_W'($urandom_range(0, 3));
            default: return wide[RT_FIELD_W-1:0];
        endcase
    endfunction

    // Stimulus: directed table, then random blocks with a varying insert mix.
    initial begin : stimulus
        int ins_pct;
        logic op;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIR_TAB[r]) begin
            for (int k = 0; k < DIR_TAB[r].reps; k++) begin
                if (DIR_TAB[r].rnd)
                    send_request(DIR_TAB[r].op, ID_W'($urandom_range(0, 65535)),
                                 pick_runtime(), 1'b0, '0);
                else
                    send_request(DIR_TAB[r].op, DIR_TAB[r].id, DIR_TAB[r].rt,
                                 DIR_TAB[r].chk, DIR_TAB[r].want);
            end
        end

        ins_pct = 50;
        for (int n = 0; n < RAND_WORDS; n++) begin
            // new mix every 40 words: fill-heavy, drain-heavy or balanced
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0:       ins_pct = 90;
                    1:       ins_pct = 25;
                    2:       ins_pct = 65;
                    default: ins_pct = 50;
                endcase
                send_burst = ($urandom_range(0, 3) == 0);
            end
            op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP;
            send_request(op, ID_W'($urandom_range(0, 65535)), pick_runtime(), 1'b0, '0);
        end
        i_s_tvalid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("least_runtime_run_queue regression: pass");
        else
            $display("least_runtime_run_queue regression: fail");
        $finish;
    end

    // Result side: random ready gaps, bursts, and one long stall so the
    // block backs up into its input.
    initial begin : result_sink
        int gap;
        bit held;
        bit rx_burst;
        t_run_result want;
        held = 1'b0;
        rx_burst = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (results_seen % 32 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 7);
            if (!held && results_seen == HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: status %0d id %h",
                       o_m_tuser, o_m_tdata[15:0]);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser);
                    err_count++;
                end
                if (o_m_tdata[15:0] !== want.id) begin
                    $error("chosen_id: expected %h, got %h", want.id, o_m_tdata[15:0]);
                    err_count++;
                end
                if (o_m_tdata[63:16] !== want.rt) begin
                    $error("chosen_runtime: expected %h, got %h", want.rt, o_m_tdata[63:16]);
                    err_count++;
                end
                if (o_m_tdata[68:64] !== want.occ) begin
                    $error("occupancy: expected %0d, got %0d", want.occ, o_m_tdata[68:64]);
                    err_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    // Watchdog: too long without a word moving on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("least_runtime_run_queue regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- files.f -----
rtl/lrq_pkg.sv
rtl/lrq_ctrl.sv
rtl/lrq_dp.sv
rtl/least_runtime_run_queue.sv
rtl/lrq_checker.sv
sim/least_runtime_run_queue_tb.sv
